/* rtl/bdll_pkg.sv */
// bdll_pkg: shared types and constants for the bucketed doubly linked lists
// holds the opcode codes, the item structs and the default sizes
// no dependencies
package bdll_pkg;

  localparam int unsigned ELEMENT_SLOTS_DEF = 1024;
  localparam int unsigned BUCKET_COUNT_DEF  = 256;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned ELEM_W   = 10;
  localparam int unsigned BKT_W    = 8;
  localparam int unsigned LINK_W   = 11;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE     = 2'd1,
    OP_READ_HEAD  = 2'd2,
    OP_READ_LINKS = 2'd3
  } op_t;

  typedef struct packed {
    op_t               opcode;
    logic [ELEM_W-1:0] element;
    logic [BKT_W-1:0]  bucket;
  } req_t;

  typedef struct packed {
    logic [LINK_W-1:0] bucket_head;
    logic [LINK_W-1:0] link_next;
    logic [LINK_W-1:0] link_prev;
  } rsp_t;

endpackage

/* rtl/bucketed_doubly_linked_lists.sv */
// bucketed_doubly_linked_lists: element slots spread over buckets, each bucket
// a doubly linked list held in on-chip memories
// depends on bdll_pkg
//
// usage:
//   request channel req_valid / req_ready / req carries one item: an opcode
//   (insert, remove, read bucket head, read element links), an element and a
//   bucket. response channel rsp_valid / rsp_ready / rsp returns exactly one
//   item per request: bucket head, next link and previous link; the value
//   ELEMENT_SLOTS stands for "no element" (truncated to the 11-bit fields).
//   items are handled one at a time. the request is taken in the idle state,
//   and that edge also issues the first memory reads. a head read is answered
//   from the first step, loading the output register when it is free;
//   insert, remove and link read with in-range operands go on to a second step.
//   insert and remove need the extra step because each link memory has a
//   single write port and both the neighbour's and the element's own links
//   change; link read needs it for the dependent read of the bucket head.
//   a request is accepted while the previous response still waits in the
//   output register; if the receiver stalls, the block holds in its last
//   step until the output register frees up.
//   after reset the head table is swept to empty, one bucket per cycle, so
//   req_ready stays low until the sweep is through. the link and bucket-record
//   memories are not cleared: they are only meaningful once written.
module bucketed_doubly_linked_lists #(
  parameter int unsigned ELEMENT_SLOTS = bdll_pkg::ELEMENT_SLOTS_DEF,
  parameter int unsigned BUCKET_COUNT  = bdll_pkg::BUCKET_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  bdll_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output bdll_pkg::rsp_t  rsp
);

  import bdll_pkg::*;

  // memory geometry follows the slot and bucket counts
  localparam int unsigned EW = $clog2(ELEMENT_SLOTS);
  localparam int unsigned BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int unsigned LW = $clog2(ELEMENT_SLOTS + 1);
  localparam logic [LW-1:0] EMPTY_L = LW'(ELEMENT_SLOTS);
  localparam logic [BW-1:0] LAST_BKT = BW'(BUCKET_COUNT - 1);
  localparam logic [LINK_W-1:0] EMPTY_O = LINK_W'(ELEMENT_SLOTS);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIRST,
    ST_SECOND
  } state_t;

  state_t state;

  // storage
  logic [LW-1:0]    head_mem [BUCKET_COUNT];
  logic [LW-1:0]    next_mem [ELEMENT_SLOTS];
  logic [LW-1:0]    prev_mem [ELEMENT_SLOTS];
  logic [BKT_W-1:0] bkt_mem  [ELEMENT_SLOTS];

  // registered read data
  logic [LW-1:0]    head_rd;
  logic [LW-1:0]    next_rd;
  logic [LW-1:0]    prev_rd;
  logic [BKT_W-1:0] bkt_rd;

  // captured request
  op_t               op_r;
  logic [ELEM_W-1:0] el_r;
  logic [BKT_W-1:0]  bk_r;
  logic              el_ok_r;
  logic              bk_ok_r;

  logic [BW-1:0] clr_idx;

  // memory port controls
  logic          head_re;
  logic [BW-1:0] head_ra;
  logic          head_we;
  logic [BW-1:0] head_wa;
  logic [LW-1:0] head_wd;
  logic          next_we;
  logic [EW-1:0] next_wa;
  logic [LW-1:0] next_wd;
  logic          prev_we;
  logic [EW-1:0] prev_wa;
  logic [LW-1:0] prev_wd;
  logic          bkt_we;

  logic accept;
  logic out_free;
  logic done;
  logic rsp_load;
  rsp_t res;

  // range checks on read-back values
  logic b_ok;
  logic old_in;
  logic p_in;
  logic n_in;
  logic [LW-1:0] rem_head;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;
  // output register takes a new item this cycle
  assign rsp_load  = out_free && ((state == ST_FIRST && done) || state == ST_SECOND);

  assign b_ok   = 32'(bkt_rd) < 32'(BUCKET_COUNT);
  assign old_in = 32'(head_rd) < 32'(ELEMENT_SLOTS);
  assign p_in   = 32'(prev_rd) < 32'(ELEMENT_SLOTS);
  assign n_in   = 32'(next_rd) < 32'(ELEMENT_SLOTS);

  // head of the element's bucket after an unlink: the successor when the
  // element was at the head, otherwise the head read back after the update
  always_comb begin
    if (!b_ok) begin
      rem_head = EMPTY_L;
    end else if (prev_rd == EMPTY_L) begin
      rem_head = next_rd;
    end else begin
      rem_head = head_rd;
    end
  end

  // head read: bucket from the request at accept, recorded bucket afterwards
  always_comb begin
    head_re = 1'b0;
    head_ra = BW'(req.bucket);
    if (accept) begin
      head_re = 1'b1;
    end else if (state == ST_FIRST &&
                 (op_r == OP_REMOVE || op_r == OP_READ_LINKS)) begin
      head_re = 1'b1;
      head_ra = BW'(bkt_rd);
    end
  end

  // write side: clear sweeps heads; first step writes head, record and neighbour
  // links and an insert's next; second step resets own prev, and next on remove
  always_comb begin
    head_we = 1'b0;
    head_wa = BW'(bk_r);
    head_wd = LW'(el_r);
    next_we = 1'b0;
    next_wa = EW'(el_r);
    next_wd = head_rd;
    prev_we = 1'b0;
    prev_wa = EW'(el_r);
    prev_wd = EMPTY_L;
    bkt_we  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_idx;
        head_wd = EMPTY_L;
      end
      ST_FIRST: begin
        case (op_r)
          OP_INSERT: begin
            if (el_ok_r && bk_ok_r) begin
              head_we = 1'b1;
              bkt_we  = 1'b1;
              next_we = 1'b1;
              if (head_rd != EMPTY_L && old_in) begin
                prev_we = 1'b1;
                prev_wa = EW'(head_rd);
                prev_wd = LW'(el_r);
              end
            end
          end
          OP_REMOVE: begin
            if (el_ok_r) begin
              if (prev_rd == EMPTY_L) begin
                head_we = b_ok;
                head_wa = BW'(bkt_rd);
                head_wd = next_rd;
              end else if (p_in) begin
                next_we = 1'b1;
                next_wa = EW'(prev_rd);
                next_wd = next_rd;
              end
              if (next_rd != EMPTY_L && n_in) begin
                prev_we = 1'b1;
                prev_wa = EW'(next_rd);
                prev_wd = prev_rd;
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_SECOND: begin
        case (op_r)
          OP_INSERT: begin
            prev_we = 1'b1;
          end
          OP_REMOVE: begin
            next_we = 1'b1;
            next_wd = EMPTY_L;
            prev_we = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // memories, one write port each, registered reads
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (head_re) begin
      head_rd <= head_mem[head_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (accept) begin
      next_rd <= next_mem[EW'(req.element)];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (accept) begin
      prev_rd <= prev_mem[EW'(req.element)];
    end
  end

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[EW'(el_r)] <= bk_r;
    end
    if (accept) begin
      bkt_rd <= bkt_mem[EW'(req.element)];
    end
  end

  // response of the current step and whether the item is finished
  always_comb begin
    done            = 1'b0;
    res.bucket_head = EMPTY_O;
    res.link_next   = EMPTY_O;
    res.link_prev   = EMPTY_O;
    if (state == ST_FIRST) begin
      case (op_r)
        OP_INSERT:     done = !(el_ok_r && bk_ok_r);
        OP_REMOVE:     done = !el_ok_r;
        OP_READ_LINKS: done = !el_ok_r;
        default: begin
          done = 1'b1;
          if (bk_ok_r) begin
            res.bucket_head = LINK_W'(head_rd);
          end
        end
      endcase
    end else if (state == ST_SECOND) begin
      done = 1'b1;
      case (op_r)
        OP_INSERT: begin
          res.bucket_head = LINK_W'(el_r);
          res.link_next   = LINK_W'(head_rd);
        end
        OP_REMOVE: begin
          res.bucket_head = LINK_W'(rem_head);
        end
        OP_READ_LINKS: begin
          if (b_ok) begin
            res.bucket_head = LINK_W'(head_rd);
          end
          res.link_next = LINK_W'(next_rd);
          res.link_prev = LINK_W'(prev_rd);
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_BKT) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_r    <= req.opcode;
            el_r    <= req.element;
            bk_r    <= req.bucket;
            el_ok_r <= 32'(req.element) < 32'(ELEMENT_SLOTS);
            bk_ok_r <= 32'(req.bucket) < 32'(BUCKET_COUNT);
            state   <= ST_FIRST;
          end
        end
        ST_FIRST: begin
          if (!done) begin
            state <= ST_SECOND;
          end else if (out_free) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        ST_SECOND: begin
          // writes here are idempotent, so holding on a stall is safe
          if (out_free) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for bucketed_doubly_linked_lists
// drives list operations, predicts every response, compares field by field
// depends on bdll_pkg and the bucketed_doubly_linked_lists rtl
module tb_top;
  import bdll_pkg::*;

  // no-element marker as the block reports it
  localparam logic [LINK_W-1:0] NO_ELEM = LINK_W'(ELEMENT_SLOTS_DEF);
  // longest stretch with no item moving on either side; the head sweep
  // after reset is the slowest part of a correct run
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 880;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b1;
  rsp_t rsp;

  // shadow of the block's lists
  logic [LINK_W-1:0] head_tbl [BUCKET_COUNT_DEF];
  logic [LINK_W-1:0] next_tbl [ELEMENT_SLOTS_DEF];
  logic [LINK_W-1:0] prev_tbl [ELEMENT_SLOTS_DEF];
  logic [BKT_W-1:0] bucket_rec [ELEMENT_SLOTS_DEF];

  // stimulus bookkeeping: elements ever inserted (safe to read or remove)
  // and elements the stimulus believes are currently linked
  bit ever_written [ELEMENT_SLOTS_DEF];
  bit in_list [ELEMENT_SLOTS_DEF];
  int written_elems [$];
  int members [$];

  rsp_t awaited_answers [$];
  int unsigned fail_count = 0;
  int unsigned answers_checked = 0;
  int unsigned op_count [4];
  int unsigned idle_cycles = 0;
  bit steady = 1'b0;

  bucketed_doubly_linked_lists DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // apply one operation to the shadow lists and return the answer it gives
  // a 10-bit element and an 8-bit bucket are always in range at these sizes;
  // only stored links can point outside the element memories
  function automatic rsp_t apply_list_op(req_t r);
    rsp_t res;
    logic [LINK_W-1:0] old_head;
    logic [LINK_W-1:0] p;
    logic [LINK_W-1:0] n;
    logic [BKT_W-1:0] b;
    res = '{NO_ELEM, NO_ELEM, NO_ELEM};
    case (r.opcode)
      OP_INSERT: begin
        old_head = head_tbl[r.bucket];
        bucket_rec[r.element] = r.bucket;
        head_tbl[r.bucket] = LINK_W'(r.element);
        if (old_head != NO_ELEM && old_head < ELEMENT_SLOTS_DEF)
          prev_tbl[old_head[ELEM_W-1:0]] = LINK_W'(r.element);
        next_tbl[r.element] = old_head;
        prev_tbl[r.element] = NO_ELEM;
        res.bucket_head = LINK_W'(r.element);
        res.link_next = old_head;
      end
      OP_REMOVE: begin
        p = prev_tbl[r.element];
        n = next_tbl[r.element];
        b = bucket_rec[r.element];
        // unlink: the predecessor or the bucket head takes the successor
        if (p == NO_ELEM)
          head_tbl[b] = n;
        else if (p < ELEMENT_SLOTS_DEF)
          next_tbl[p[ELEM_W-1:0]] = n;
        if (n != NO_ELEM && n < ELEMENT_SLOTS_DEF)
          prev_tbl[n[ELEM_W-1:0]] = p;
        prev_tbl[r.element] = NO_ELEM;
        next_tbl[r.element] = NO_ELEM;
        res.bucket_head = head_tbl[b];
      end
      OP_READ_HEAD: res.bucket_head = head_tbl[r.bucket];
      default: begin
        res.bucket_head = head_tbl[bucket_rec[r.element]];
        res.link_next = next_tbl[r.element];
        res.link_prev = prev_tbl[r.element];
      end
    endcase
    return res;
  endfunction

  // present one item, wait for its handshake, then predict and book it
  // valid is only lowered when a gap follows, so it never drops and rises
  // in the same step
  task automatic send_item(input op_t op, input int element, input int bucket);
    int gap;
    int idxq [$];
    req_t item;
    item.opcode = op;
    item.element = ELEM_W'(element);
    item.bucket = BKT_W'(bucket);
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    awaited_answers.push_back(apply_list_op(item));
    op_count[op]++;
    if (op == OP_INSERT) begin
      if (!ever_written[item.element]) written_elems.push_back(item.element);
      ever_written[item.element] = 1'b1;
      if (!in_list[item.element]) members.push_back(item.element);
      in_list[item.element] = 1'b1;
    end else if (op == OP_REMOVE && in_list[item.element]) begin
      idxq = members.find_first_index(m) with (m == item.element);
      if (idxq.size() > 0) members.delete(idxq[0]);
      in_list[item.element] = 1'b0;
    end
  endtask

  // hold the sender until every response has come back
  task automatic drain_answers();
    req_valid <= 1'b0;
    @(posedge clk);
    while (awaited_answers.size() > 0) @(posedge clk);
  endtask

  // mostly a handful of buckets so lists grow long, sometimes any bucket
  function automatic int pick_bucket();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
  endfunction

  // fresh heads after the sweep, at both ends of the bucket range
  task automatic test_empty_heads();
    send_item(OP_READ_HEAD, $urandom_range(0, 1023), 0);
    send_item(OP_READ_HEAD, $urandom_range(0, 1023), 255);
  endtask

  // build a three element list, then cut it from the middle, the tail and
  // the head; the bucket field of removes and link reads is junk
  task automatic test_list_surgery();
    send_item(OP_INSERT, 0, 0);
    send_item(OP_INSERT, 1023, 0);
    send_item(OP_INSERT, 512, 0);
    send_item(OP_READ_LINKS, 1023, 255);
    send_item(OP_READ_LINKS, 0, 255);
    send_item(OP_REMOVE, 1023, 255);
    send_item(OP_READ_LINKS, 512, 0);
    send_item(OP_READ_LINKS, 0, 170);
    send_item(OP_REMOVE, 0, 85);
    send_item(OP_REMOVE, 512, 0);
    send_item(OP_READ_HEAD, 0, 0);
    drain_answers();
  endtask

  // caller misuse the block does not guard against: removing an element
  // that is already out (clobbers its old bucket head) and inserting one
  // twice at the head of its own bucket (self loop)
  task automatic test_unchecked_misuse();
    send_item(OP_INSERT, 7, 200);
    send_item(OP_INSERT, 9, 200);
    send_item(OP_REMOVE, 7, 0);
    send_item(OP_REMOVE, 7, 0);
    send_item(OP_READ_HEAD, 0, 200);
    send_item(OP_INSERT, 341, 201);
    send_item(OP_INSERT, 341, 201);
    send_item(OP_READ_LINKS, 341, 0);
    send_item(OP_REMOVE, 341, 0);
    send_item(OP_READ_HEAD, 0, 201);
  endtask

  // mostly well-formed traffic with a little misuse mixed in
  task automatic test_random_traffic();
    int roll;
    int e;
    int idx;
    int tries;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // alternate stretches with and without idling on both sides
      if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) drain_answers();
      roll = $urandom_range(0, 99);
      if (members.size() > 250 && roll < 40) roll = 50;
      if (members.size() == 0 && roll >= 40 && roll < 80) roll = 0;
      if (roll < 40) begin
        do e = $urandom_range(0, 1023); while (in_list[e]);
        send_item(OP_INSERT, e, pick_bucket());
      end else if (roll < 65) begin
        idx = $urandom_range(0, members.size() - 1);
        send_item(OP_REMOVE, members[idx], $urandom_range(0, 255));
      end else if (roll < 80) begin
        if (members.size() > 0 && $urandom_range(0, 9) < 7)
          e = members[$urandom_range(0, members.size() - 1)];
        else
          e = written_elems[$urandom_range(0, written_elems.size() - 1)];
        send_item(OP_READ_LINKS, e, $urandom_range(0, 255));
      end else if (roll < 94) begin
        send_item(OP_READ_HEAD, $urandom_range(0, 1023), pick_bucket());
      end else if (roll < 97 && members.size() > 0) begin
        // double insert, possibly into another bucket
        e = members[$urandom_range(0, members.size() - 1)];
        send_item(OP_INSERT, e, pick_bucket());
      end else begin
        // remove of an element that is already out, if one is found
        tries = 0;
        do begin
          e = written_elems[$urandom_range(0, written_elems.size() - 1)];
          tries++;
        end while (in_list[e] && tries < 8);
        send_item(in_list[e] ? OP_READ_LINKS : OP_REMOVE, e, $urandom_range(0, 255));
      end
    end
    steady = 1'b0;
  endtask

  // response side: random stalls per item, every response checked
  initial begin : rsp_side
    int hold;
    rsp_t want;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (rsp_valid && rsp_ready) begin
          if (awaited_answers.size() == 0) begin
            $error("response item with no request outstanding");
            fail_count++;
          end else begin
            want = awaited_answers.pop_front();
            answers_checked++;
            if (rsp.bucket_head !== want.bucket_head) begin
              $error("bucket_head: expected %0d, actual %0d", want.bucket_head,
                     rsp.bucket_head);
              fail_count++;
            end
            if (rsp.link_next !== want.link_next) begin
              $error("link_next: expected %0d, actual %0d", want.link_next,
                     rsp.link_next);
              fail_count++;
            end
            if (rsp.link_prev !== want.link_prev) begin
              $error("link_prev: expected %0d, actual %0d", want.link_prev,
                     rsp.link_prev);
              fail_count++;
            end
          end
          hold = steady ? 0 : $urandom_range(0, 11);
          if (hold > 0) rsp_ready <= 1'b0;
        end else if (!rsp_ready) begin
          hold--;
          if (hold <= 0) rsp_ready <= 1'b1;
        end
      end
    end
  end

  // watchdog: too long without any item moving ends the run
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("bucketed_doubly_linked_lists verification failed");
        $finish;
      end
    end
  end

  initial begin
    // shadow state after reset: heads empty, the rest never read unwritten
    foreach (head_tbl[i]) head_tbl[i] = NO_ELEM;
    foreach (next_tbl[i]) begin
      next_tbl[i] = '0;
      prev_tbl[i] = '0;
      bucket_rec[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_empty_heads();
    test_list_surgery();
    test_unchecked_misuse();
    test_random_traffic();

    // let the last responses come home, then watch for strays
    drain_answers();
    repeat (20) @(posedge clk);

    $display("covered %0d inserts, %0d removes, %0d head reads, %0d link reads",
             op_count[OP_INSERT], op_count[OP_REMOVE], op_count[OP_READ_HEAD],
             op_count[OP_READ_LINKS]);
    $display("%0d responses checked, %0d elements still linked, %0d errors",
             answers_checked, members.size(), fail_count);
    if (fail_count == 0) begin
      $display("bucketed_doubly_linked_lists verification clean");
    end else begin
      $display("bucketed_doubly_linked_lists verification failed");
    end
    $finish;
  end

endmodule
